// ----- hdl/tsfrs_pkg.sv -----
package tsfrs_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int IDX_W      = $clog2(MAX_TASKS);
   localparam int CNT_W      = $clog2(MAX_TASKS + 1);
   localparam int TIME_W     = 24;
   localparam int QUANT_W    = 16;
   localparam int POL_W      = 2;
   localparam int TCNT_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
   localparam logic [POL_W-1:0] POL_RR   = 2'd1;
   localparam logic [POL_W-1:0] POL_SJF  = 2'd2;
   localparam logic [POL_W-1:0] POL_SRT  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUANTUM    = 2'd2;

   localparam logic [TCNT_W-1:0]  TASK_COUNT_RESET = 5'd1;
   localparam logic [QUANT_W-1:0] QUANTUM_RESET    = 16'd500;

   localparam logic        ACT_LOAD = 1'b0;
   localparam logic        ACT_TICK = 1'b1;

   // slot code meaning "nothing running"
   localparam logic [CNT_W-1:0] TASK_NONE = CNT_W'(MAX_TASKS);

   typedef struct packed {
      logic              action;
      logic [TIME_W-1:0] arrival_time;
      logic [TIME_W-1:0] run_length;
   } req_type;

   typedef struct packed {
      logic              run_valid;
      logic [3:0]        run_index;
      logic              switched;
      logic              first_start;
      logic              finished_valid;
      logic [3:0]        finished_index;
      logic              all_done;
      logic [TIME_W-1:0] tick_time;
   } rsp_type;

   typedef struct packed {
      logic             push;
      logic             pop;
      logic [IDX_W-1:0] push_idx;
   } qcmd_type;

endpackage

// ----- hdl/tsfrs_mod.sv -----
module tsfrs_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tsfrs_pkg::TIME_W-1:0]  dividend,
   input  logic [tsfrs_pkg::QUANT_W-1:0] divisor,
   output logic                          done,
   output logic                          zero
);
   import tsfrs_pkg::*;

   localparam int CW = $clog2(TIME_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CW-1:0]     cnt_ff;
   logic [TIME_W-1:0] dvd_ff;
   logic [QUANT_W-1:0] dsr_ff;
   logic [QUANT_W-1:0] rem_ff;
   logic [QUANT_W:0]  shifted;

   // restoring remainder, one dividend bit per cycle
   assign shifted = {rem_ff, dvd_ff[TIME_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(TIME_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= (divisor == '0) ? QUANT_W'(1) : divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[TIME_W-2:0], 1'b0};
         if (shifted >= {1'b0, dsr_ff}) rem_ff <= QUANT_W'(shifted - {1'b0, dsr_ff});
         else                           rem_ff <= shifted[QUANT_W-1:0];
      end
   end

   assign done = done_ff;
   assign zero = (rem_ff == '0);

endmodule

// ----- hdl/tsfrs_queue.sv -----
module tsfrs_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  tsfrs_pkg::qcmd_type           cmd,
   output logic [tsfrs_pkg::CNT_W-1:0]   count,
   output logic [tsfrs_pkg::IDX_W-1:0]   pop_idx
);
   import tsfrs_pkg::*;

   logic [IDX_W-1:0] mem [MAX_TASKS];
   logic [IDX_W-1:0] head_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] pop_ff;
   logic [CNT_W:0]   pos_sum;
   logic [IDX_W-1:0] tail;
   logic             do_push;
   logic             do_pop;

   assign pos_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign tail    = (pos_sum >= (CNT_W+1)'(MAX_TASKS))
                    ? IDX_W'(pos_sum - (CNT_W+1)'(MAX_TASKS)) : IDX_W'(pos_sum);
   // a push into a full queue is dropped
   assign do_push = cmd.push && (count_ff < CNT_W'(MAX_TASKS));
   assign do_pop  = !do_push && cmd.pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (do_push) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_ff <= count_ff - CNT_W'(1);
         head_ff  <= (head_ff == IDX_W'(MAX_TASKS - 1)) ? '0 : head_ff + IDX_W'(1);
      end
   end

   // popped entry is held until the next pop
   always_ff @(posedge clock) begin
      if (do_push) mem[tail] <= cmd.push_idx;
      if (do_pop)  pop_ff <= mem[head_ff];
   end

   assign count   = count_ff;
   assign pop_idx = pop_ff;

endmodule

// ----- hdl/task_scheduler_fifo_rr_sjf.sv -----
// Single-processor task scheduler: FIFO, round robin, shortest job first,
// shortest remaining time.
// req channel (req_valid/req_stall/req_data): action 0 loads the next table
// slot with an arrival time and run length; action 1 runs one
// scheduling tick. rsp channel (rsp_valid/rsp_stall/rsp_data) returns one
// beat per tick and none per load.
// csr port writes policy, task_count and quantum; write only while idle.
// A tick's first pass over the active slots (up to 16) admits new tasks;
// FIFO or SJF then keeps a running task, and a second pass finds the
// minimum when FIFO or SJF has nothing running, and on every SRT tick.
// Round robin pops the ready queue when nothing runs, and otherwise tests
// the running task's slice with the bit-serial remainder unit (one time
// bit per cycle), popping the queue when the slice is up. Ticks that only
// hold the all-done state skip the passes; a tick that retires the last
// task ends after the retire check.
// One item is worked at a time; req_stall is high while a tick is in flight.
// The rsp output register holds a finished beat while the receiver stalls;
// the next item is still taken, and its beat waits for the register.
// Reset (synchronous) empties the table, the ready queue and all counters,
// sets time to zero and restores policy FIFO, task_count 1, quantum 500.
module task_scheduler_fifo_rr_sjf (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tsfrs_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tsfrs_pkg::rsp_type               rsp_data,
   input  logic                             csr_we,
   input  logic [tsfrs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tsfrs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tsfrs_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHK    = 4'd1;
   localparam logic [3:0] S_ADM    = 4'd2;
   localparam logic [3:0] S_PICK   = 4'd3;
   localparam logic [3:0] S_MOD    = 4'd4;
   localparam logic [3:0] S_POP    = 4'd5;
   localparam logic [3:0] S_POPCHK = 4'd6;
   localparam logic [3:0] S_SCAN   = 4'd7;
   localparam logic [3:0] S_APPLY  = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   // config
   logic [POL_W-1:0]   policy_ff;
   logic [TCNT_W-1:0]  tcount_ff;
   logic [QUANT_W-1:0] quantum_ff;

   // task tables
   logic [TIME_W-1:0] arr_mem [MAX_TASKS];
   logic [TIME_W-1:0] rem_mem [MAX_TASKS];
   logic [TIME_W-1:0] arr_rd_ff;
   logic [TIME_W-1:0] rem_rd_ff;
   logic [IDX_W-1:0]  rem_ra;
   logic              rem_we;
   logic [IDX_W-1:0]  rem_wa;
   logic [TIME_W-1:0] rem_wd;

   logic [3:0]           state_ff;
   logic [MAX_TASKS-1:0] arrived_ff;
   logic [MAX_TASKS-1:0] started_ff;
   logic [CNT_W-1:0]     cur_ff;
   logic [CNT_W-1:0]     nxt_ff;
   logic [TIME_W-1:0]    cur_rem_ff;
   logic [TIME_W-1:0]    sel_rem_ff;
   logic [TIME_W-1:0]    last_sw_ff;
   logic [TIME_W-1:0]    time_ff;
   logic [CNT_W-1:0]     fin_tot_ff;
   logic [CNT_W-1:0]     loaded_ff;
   logic [CNT_W-1:0]     n_ff;
   logic [CNT_W-1:0]     lim_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [IDX_W-1:0]     pidx_ff;
   logic                 pvld_ff;
   logic [CNT_W-1:0]     best_ff;
   logic [TIME_W-1:0]    best_key_ff;
   logic [TIME_W-1:0]    best_rem_ff;
   logic                 fin_v_ff;
   logic [IDX_W-1:0]     fin_i_ff;
   rsp_type              res_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic              req_go;
   logic              load_go;
   logic [CNT_W-1:0]  n_now;
   logic [CNT_W-1:0]  lim_now;
   logic              out_free;
   logic              scan_end;
   logic              admit;
   logic              kept_np;
   logic              do_pop;
   logic              mod_start;
   logic              mod_done;
   logic              mod_zero;
   logic [TIME_W-1:0] scan_key;
   logic              scan_take;
   logic              sw;
   logic [CNT_W-1:0]  run_task;
   logic [TIME_W-1:0] run_rem;
   logic              run_on;
   logic [TIME_W-1:0] time_inc;
   qcmd_type          qcmd;
   logic [CNT_W-1:0]  q_count;
   logic [IDX_W-1:0]  q_pop_idx;

   assign req_stall = (state_ff != S_IDLE);
   assign req_go    = req_valid && !req_stall;
   assign load_go   = req_go && (req_data.action == ACT_LOAD)
                      && (loaded_ff < CNT_W'(MAX_TASKS));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // active task count: 0 acts as 1, clipped to table size
   always_comb begin
      if (tcount_ff == '0)                        n_now = CNT_W'(1);
      else if (32'(tcount_ff) > 32'(MAX_TASKS))   n_now = CNT_W'(MAX_TASKS);
      else                                        n_now = CNT_W'(tcount_ff);
      lim_now = (n_now < loaded_ff) ? n_now : loaded_ff;
   end

   // scan pipeline: address at idx, compare in the next cycle at pidx
   assign scan_end = (idx_ff >= lim_ff) && !pvld_ff;
   assign admit    = pvld_ff && (arr_rd_ff == time_ff) && !arrived_ff[pidx_ff];
   assign scan_key = (policy_ff == POL_FIFO) ? arr_rd_ff : rem_rd_ff;
   assign scan_take = pvld_ff && arrived_ff[pidx_ff] && (rem_rd_ff != '0)
                      && ((best_ff == TASK_NONE) || (scan_key < best_key_ff));

   assign kept_np   = (cur_ff != TASK_NONE)
                      && ((policy_ff == POL_FIFO) || (policy_ff == POL_SJF));
   assign mod_start = (state_ff == S_PICK) && !kept_np && (policy_ff == POL_RR)
                      && (cur_ff != TASK_NONE);
   assign do_pop    = ((state_ff == S_PICK) && !kept_np && (policy_ff == POL_RR)
                       && (cur_ff == TASK_NONE))
                      || ((state_ff == S_MOD) && mod_done && mod_zero);

   // queue commands
   always_comb begin
      qcmd = '0;
      if (state_ff == S_ADM && admit) begin
         qcmd.push     = 1'b1;
         qcmd.push_idx = pidx_ff;
      end else if (state_ff == S_POPCHK && rem_rd_ff != '0 && cur_ff != TASK_NONE) begin
         // preempted task goes to the back
         qcmd.push     = 1'b1;
         qcmd.push_idx = cur_ff[IDX_W-1:0];
      end
      qcmd.pop = do_pop && (q_count != '0);
   end

   // commit of the chosen task
   assign sw       = (nxt_ff != TASK_NONE) && (nxt_ff != cur_ff);
   assign run_task = sw ? nxt_ff : cur_ff;
   assign run_rem  = sw ? sel_rem_ff : cur_rem_ff;
   assign run_on   = (run_task != TASK_NONE);
   assign time_inc = (time_ff != '1) ? time_ff + TIME_W'(1) : time_ff;

   always_comb begin
      unique case (state_ff)
         S_IDLE:  rem_ra = cur_ff[IDX_W-1:0];
         S_POP:   rem_ra = q_pop_idx;
         default: rem_ra = idx_ff[IDX_W-1:0];
      endcase
   end

   always_comb begin
      rem_we = 1'b0;
      rem_wa = loaded_ff[IDX_W-1:0];
      rem_wd = (req_data.run_length == '0) ? TIME_W'(1) : req_data.run_length;
      if (load_go) begin
         rem_we = 1'b1;
      end else if (state_ff == S_APPLY && run_on) begin
         rem_we = 1'b1;
         rem_wa = run_task[IDX_W-1:0];
         rem_wd = run_rem - TIME_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load_go) arr_mem[loaded_ff[IDX_W-1:0]] <= req_data.arrival_time;
      if (rem_we)  rem_mem[rem_wa] <= rem_wd;
      arr_rd_ff <= arr_mem[idx_ff[IDX_W-1:0]];
      rem_rd_ff <= rem_mem[rem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= POL_FIFO;
         tcount_ff  <= TASK_COUNT_RESET;
         quantum_ff <= QUANTUM_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POLICY:     policy_ff  <= csr_wdata[POL_W-1:0];
            CSR_TASK_COUNT: tcount_ff  <= csr_wdata[TCNT_W-1:0];
            CSR_QUANTUM:    quantum_ff <= csr_wdata[QUANT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         arrived_ff <= '0;
         started_ff <= '0;
         cur_ff     <= TASK_NONE;
         last_sw_ff <= '0;
         time_ff    <= '0;
         fin_tot_ff <= '0;
         loaded_ff  <= '0;
         pvld_ff    <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (load_go) loaded_ff <= loaded_ff + CNT_W'(1);
               if (req_go && req_data.action == ACT_TICK) begin
                  n_ff   <= n_now;
                  lim_ff <= lim_now;
                  if (fin_tot_ff >= n_now) begin
                     // everything finished: frozen tick
                     res_ff   <= '{run_valid: 1'b0, run_index: 4'd0, switched: 1'b0,
                                   first_start: 1'b0, finished_valid: 1'b0,
                                   finished_index: 4'd0, all_done: 1'b1,
                                   tick_time: time_ff};
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_CHK;
                  end
               end
            end
            S_CHK: begin
               idx_ff     <= '0;
               pvld_ff    <= 1'b0;
               cur_rem_ff <= rem_rd_ff;
               if (cur_ff != TASK_NONE && rem_rd_ff == '0) begin
                  // retire the finished task
                  fin_v_ff   <= 1'b1;
                  fin_i_ff   <= cur_ff[IDX_W-1:0];
                  cur_ff     <= TASK_NONE;
                  fin_tot_ff <= fin_tot_ff + CNT_W'(1);
                  if (fin_tot_ff + CNT_W'(1) >= n_ff) begin
                     res_ff   <= '{run_valid: 1'b0, run_index: 4'd0, switched: 1'b0,
                                   first_start: 1'b0, finished_valid: 1'b1,
                                   finished_index: 4'(cur_ff[IDX_W-1:0]),
                                   all_done: 1'b1, tick_time: time_ff};
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_ADM;
                  end
               end else begin
                  fin_v_ff <= 1'b0;
                  fin_i_ff <= '0;
                  state_ff <= S_ADM;
               end
            end
            S_ADM: begin
               if (admit) arrived_ff[pidx_ff] <= 1'b1;
               pidx_ff <= idx_ff[IDX_W-1:0];
               pvld_ff <= (idx_ff < lim_ff);
               if (idx_ff < lim_ff) idx_ff <= idx_ff + CNT_W'(1);
               if (scan_end) state_ff <= S_PICK;
            end
            S_PICK: begin
               idx_ff      <= '0;
               pvld_ff     <= 1'b0;
               best_ff     <= TASK_NONE;
               best_key_ff <= '0;
               best_rem_ff <= '0;
               if (kept_np) begin
                  nxt_ff   <= cur_ff;
                  state_ff <= S_APPLY;
               end else if (policy_ff == POL_RR) begin
                  if (cur_ff != TASK_NONE) begin
                     state_ff <= S_MOD;
                  end else if (q_count != '0) begin
                     state_ff <= S_POP;
                  end else begin
                     nxt_ff   <= cur_ff;
                     state_ff <= S_APPLY;
                  end
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  if (mod_zero && q_count != '0) begin
                     state_ff <= S_POP;
                  end else begin
                     nxt_ff   <= cur_ff;
                     state_ff <= S_APPLY;
                  end
               end
            end
            S_POP: state_ff <= S_POPCHK;
            S_POPCHK: begin
               // a finished task popped from the queue counts as an empty pop
               if (rem_rd_ff == '0) begin
                  nxt_ff <= cur_ff;
               end else begin
                  nxt_ff     <= CNT_W'(q_pop_idx);
                  sel_rem_ff <= rem_rd_ff;
               end
               state_ff <= S_APPLY;
            end
            S_SCAN: begin
               if (scan_take) begin
                  best_ff     <= CNT_W'(pidx_ff);
                  best_key_ff <= scan_key;
                  best_rem_ff <= rem_rd_ff;
               end
               pidx_ff <= idx_ff[IDX_W-1:0];
               pvld_ff <= (idx_ff < lim_ff);
               if (idx_ff < lim_ff) idx_ff <= idx_ff + CNT_W'(1);
               if (scan_end) begin
                  nxt_ff     <= best_ff;
                  sel_rem_ff <= best_rem_ff;
                  state_ff   <= S_APPLY;
               end
            end
            S_APPLY: begin
               if (sw) begin
                  started_ff[nxt_ff[IDX_W-1:0]] <= 1'b1;
                  cur_ff     <= nxt_ff;
                  last_sw_ff <= time_ff;
               end
               res_ff   <= '{run_valid: run_on,
                             run_index: run_on ? 4'(run_task[IDX_W-1:0]) : 4'd0,
                             switched: sw,
                             first_start: sw && !started_ff[nxt_ff[IDX_W-1:0]],
                             finished_valid: fin_v_ff,
                             finished_index: 4'(fin_i_ff),
                             all_done: 1'b0,
                             tick_time: time_ff};
               time_ff  <= time_inc;
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EMIT && out_free) rsp_data_ff <= res_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tsfrs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (qcmd),
      .count   (q_count),
      .pop_idx (q_pop_idx)
   );

   tsfrs_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (mod_start),
      .dividend (time_ff - last_sw_ff),
      .divisor  (quantum_ff),
      .done     (mod_done),
      .zero     (mod_zero)
   );

`ifndef SYNTHESIS
   a_cur_range: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= TASK_NONE)
      else $error("current task out of range");

   a_counts: assert property (@(posedge clock) disable iff (reset)
      (loaded_ff <= CNT_W'(MAX_TASKS)) && (fin_tot_ff <= CNT_W'(MAX_TASKS)))
      else $error("task counters overflow");

   a_run_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && run_on) |-> (run_rem != '0))
      else $error("running task has no work left");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && out_free) |=> rsp_valid_ff)
      else $error("result beat not presented");
`endif

endmodule

// ----- bench/task_scheduler_fifo_rr_sjf_tb.sv -----
`timescale 1ns / 100ps

module task_scheduler_fifo_rr_sjf_tb;
   import tsfrs_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 200;
   localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

   // idle profiles, percent of cycles that a side holds off
   typedef enum int {PH_NONE, PH_SEND, PH_RECV, PH_BOTH} idle_phase_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   task_scheduler_fifo_rr_sjf uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------
   // Scheduler shadow state: mirrors the block's table, queue and time.
   // ---------------------------------------------------------------
   logic [POL_W-1:0]   sh_policy;
   logic [TCNT_W-1:0]  sh_task_count;
   logic [QUANT_W-1:0] sh_quantum;
   logic [TIME_W-1:0]  sh_arrival [MAX_TASKS];
   logic [TIME_W-1:0]  sh_remain  [MAX_TASKS];
   logic [MAX_TASKS-1:0] sh_arrived, sh_started;
   int sh_rq [MAX_TASKS];
   int sh_head, sh_qcount, sh_current, sh_finished, sh_loaded;
   logic [TIME_W-1:0] sh_last_switch, sh_now;

   rsp_type sched_expect_q[$];   // expected tick beats, oldest first
   req_type pending_beats[$];    // items waiting for the driver

   int errors = 0;
   int ticks_checked = 0;
   int done_seen = 0;

   function automatic void shadow_reset();
      sh_policy = POL_FIFO;
      sh_task_count = TASK_COUNT_RESET;
      sh_quantum = QUANTUM_RESET;
      for (int i = 0; i < MAX_TASKS; i++) begin
         sh_arrival[i] = '0;
         sh_remain[i] = '0;
         sh_rq[i] = 0;
      end
      sh_arrived = '0;
      sh_started = '0;
      sh_head = 0;
      sh_qcount = 0;
      sh_current = MAX_TASKS;
      sh_finished = 0;
      sh_loaded = 0;
      sh_last_switch = '0;
      sh_now = '0;
   endfunction

   function automatic void rq_push(int t);
      if (sh_qcount >= MAX_TASKS) return;
      sh_rq[(sh_head + sh_qcount) % MAX_TASKS] = t;
      sh_qcount++;
   endfunction

   // a popped entry that already finished counts as an empty pop
   function automatic int rq_pop();
      int t;
      if (sh_qcount == 0) return MAX_TASKS;
      t = sh_rq[sh_head];
      sh_head = (sh_head + 1) % MAX_TASKS;
      sh_qcount--;
      if (t >= MAX_TASKS || sh_remain[t] == 0) return MAX_TASKS;
      return t;
   endfunction

   function automatic int pick_task(int lim);
      int t;
      int q;
      int unsigned dt;
      t = MAX_TASKS;
      if (sh_current != MAX_TASKS && (sh_policy == POL_FIFO || sh_policy == POL_SJF))
         return sh_current;
      if (sh_policy == POL_RR) begin
         q = (sh_quantum == 0) ? 1 : sh_quantum;
         dt = TIME_W'(sh_now - sh_last_switch);
         if (sh_current == MAX_TASKS || dt % q == 0) begin
            t = rq_pop();
            if (t == MAX_TASKS) return sh_current;
            if (sh_current != MAX_TASKS) rq_push(sh_current);
            return t;
         end
         return sh_current;
      end
      for (int i = 0; i < lim; i++) begin
         if (!sh_arrived[i] || sh_remain[i] == 0) continue;
         if (t == MAX_TASKS) t = i;
         else if (sh_policy == POL_FIFO ? sh_arrival[i] < sh_arrival[t]
                                        : sh_remain[i] < sh_remain[t]) t = i;
      end
      return t;
   endfunction

   // Apply one accepted beat to the shadow; ticks queue an expected response.
   function automatic void sched_apply(req_type r);
      int n, lim, nxt;
      rsp_type e;
      if (r.action == ACT_LOAD) begin
         if (sh_loaded < MAX_TASKS) begin
            sh_arrival[sh_loaded] = r.arrival_time;
            sh_remain[sh_loaded] = (r.run_length == '0) ? TIME_W'(1) : r.run_length;
            sh_loaded++;
         end
         return;
      end
      n = (sh_task_count == 0) ? 1 : (sh_task_count > MAX_TASKS ? MAX_TASKS : sh_task_count);
      lim = (n < sh_loaded) ? n : sh_loaded;
      e = '0;
      e.tick_time = sh_now;
      if (sh_finished >= n) begin
         e.all_done = 1'b1;
         sched_expect_q.push_back(e);
         return;
      end
      if (sh_current != MAX_TASKS && sh_remain[sh_current] == 0) begin
         e.finished_valid = 1'b1;
         e.finished_index = 4'(sh_current);
         sh_current = MAX_TASKS;
         sh_finished++;
         if (sh_finished >= n) begin
            e.all_done = 1'b1;
            sched_expect_q.push_back(e);
            return;
         end
      end
      for (int i = 0; i < lim; i++) begin
         if (sh_arrival[i] == sh_now && !sh_arrived[i]) begin
            sh_arrived[i] = 1'b1;
            rq_push(i);
         end
      end
      nxt = pick_task(lim);
      if (nxt != MAX_TASKS && nxt != sh_current) begin
         e.switched = 1'b1;
         e.first_start = !sh_started[nxt];
         sh_started[nxt] = 1'b1;
         sh_current = nxt;
         sh_last_switch = sh_now;
      end
      if (sh_current != MAX_TASKS) begin
         e.run_valid = 1'b1;
         e.run_index = 4'(sh_current);
         if (sh_remain[sh_current] != 0) sh_remain[sh_current]--;
      end
      if (sh_now != T_MAX) sh_now++;
      sched_expect_q.push_back(e);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // ---------------------------------------------------------------
   // Driver: offers queued beats; a beat counts when valid && !stall.
   // ---------------------------------------------------------------
   idle_phase_type phase;
   bit hold_send;        // pause sender completely
   int hold_req_cnt;     // bumped to request a long receiver hold-off
   int hold_ack_cnt;
   int recv_holdoff;     // cycles the receiver still holds off
   int idle_cycles;      // watchdog: cycles with nothing accepted

   function automatic bit roll(int pct);
      return $urandom_range(99) < pct;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
      end else begin
         // beat taken this edge?
         if (req_valid && !req_stall) begin
            sched_apply(req_data);
            void'(pending_beats.pop_front());
         end
         if (req_valid && req_stall) begin
            // payload held while stalled
         end else if (pending_beats.size() != 0 && !hold_send) begin
            if ((phase == PH_SEND && roll(81)) || (phase == PH_BOTH && roll(7))) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= pending_beats[0];
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         recv_holdoff <= 0;
         hold_ack_cnt <= hold_req_cnt;
      end else if (hold_ack_cnt != hold_req_cnt) begin
         recv_holdoff <= 400;
         hold_ack_cnt <= hold_req_cnt;
      end else if (recv_holdoff > 0) begin
         recv_holdoff <= recv_holdoff - 1;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: compares each response beat with the oldest expectation.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sched_expect_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_data.tick_time, 0);
            end else begin
               e = sched_expect_q.pop_front();
               ticks_checked++;
               if (e.all_done) done_seen++;
               if (rsp_data.run_valid != e.run_valid)
                  report_mismatch("run_valid", rsp_data.run_valid, e.run_valid);
               if (rsp_data.run_index != e.run_index)
                  report_mismatch("run_index", rsp_data.run_index, e.run_index);
               if (rsp_data.switched != e.switched)
                  report_mismatch("switched", rsp_data.switched, e.switched);
               if (rsp_data.first_start != e.first_start)
                  report_mismatch("first_start", rsp_data.first_start, e.first_start);
               if (rsp_data.finished_valid != e.finished_valid)
                  report_mismatch("finished_valid", rsp_data.finished_valid,
                                  e.finished_valid);
               if (rsp_data.finished_index != e.finished_index)
                  report_mismatch("finished_index", rsp_data.finished_index,
                                  e.finished_index);
               if (rsp_data.all_done != e.all_done)
                  report_mismatch("all_done", rsp_data.all_done, e.all_done);
               if (rsp_data.tick_time != e.tick_time)
                  report_mismatch("tick_time", rsp_data.tick_time, e.tick_time);
            end
         end
         if (recv_holdoff > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (phase == PH_RECV && roll(81)) || (phase == PH_BOTH && roll(7));
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   function automatic req_type mk_load(logic [TIME_W-1:0] arr, logic [TIME_W-1:0] len);
      req_type r;
      r.action = ACT_LOAD;
      r.arrival_time = arr;
      r.run_length = len;
      return r;
   endfunction

   function automatic req_type mk_tick();
      req_type r;
      r.action = ACT_TICK;
      r.arrival_time = TIME_W'($urandom);   // don't-care content on ticks
      r.run_length = TIME_W'($urandom);
      return r;
   endfunction

   // wait for the driver to drain and every expected beat to come back
   task automatic wait_quiet();
      while (pending_beats.size() != 0 || req_valid || sched_expect_q.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);   // loads give no beat; let a late one settle
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_POLICY:     sh_policy = v[POL_W-1:0];
         CSR_TASK_COUNT: sh_task_count = v[TCNT_W-1:0];
         CSR_QUANTUM:    sh_quantum = v[QUANT_W-1:0];
         default: ;
      endcase
   endtask

   // Loads must precede the ticks that reach them; a set is sorted by arrival.
   // Random job set with small times so arrivals actually hit the clock.
   task automatic queue_job_set(input int ntasks, input int spread, input int maxlen,
                                input int nticks);
      logic [TIME_W-1:0] arr;
      arr = '0;
      for (int i = 0; i < ntasks; i++) begin
         arr = arr + TIME_W'($urandom_range(spread));
         pending_beats.push_back(mk_load(arr, TIME_W'($urandom_range(maxlen))));
      end
      for (int i = 0; i < nticks; i++) pending_beats.push_back(mk_tick());
   endtask

   // all runs share the one reset, so the table is loaded once; later
   // sets see extra loads ignored and done ticks
   initial begin
      int nt;
      phase = PH_NONE;
      hold_send = 1'b0;
      hold_req_cnt = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      shadow_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: policy RR, quantum 1, four tasks with field extremes.
      csr_write(CSR_POLICY, CSR_DATA_W'(POL_RR));
      csr_write(CSR_TASK_COUNT, CSR_DATA_W'(0));     // acts as 1 at first
      csr_write(CSR_QUANTUM, CSR_DATA_W'(0));        // acts as 1
      pending_beats.push_back(mk_tick());            // nothing loaded yet
      pending_beats.push_back(mk_load('0, '0));      // zero run raised to one
      pending_beats.push_back(mk_load('0, 24'd3));
      pending_beats.push_back(mk_load(24'd1, 24'd2));
      pending_beats.push_back(mk_load(24'd2, 24'd1));
      for (int i = 0; i < 6; i++) pending_beats.push_back(mk_tick());
      wait_quiet();
      // raise count mid-run; policy change mid-run leaves stale queue entries
      csr_write(CSR_TASK_COUNT, CSR_DATA_W'(31));    // above max acts as 16
      csr_write(CSR_POLICY, CSR_DATA_W'(POL_SRT));
      for (int i = 0; i < 12; i++)
         pending_beats.push_back(mk_load(TIME_W'(3 + i), (i == 11) ? T_MAX : TIME_W'(i % 4)));
      pending_beats.push_back(mk_load(T_MAX, 24'd1)); // 17th load ignored
      for (int i = 0; i < 8; i++) pending_beats.push_back(mk_tick());
      wait_quiet();
      csr_write(CSR_POLICY, CSR_DATA_W'(POL_RR));
      csr_write(CSR_QUANTUM, CSR_DATA_W'(2));
      for (int i = 0; i < 10; i++) pending_beats.push_back(mk_tick());
      wait_quiet();
      csr_write(CSR_POLICY, CSR_DATA_W'(POL_SJF));
      for (int i = 0; i < 10; i++) pending_beats.push_back(mk_tick());
      wait_quiet();
      csr_write(CSR_POLICY, CSR_DATA_W'(POL_FIFO));
      csr_write(CSR_QUANTUM, CSR_DATA_W'(16'hFFFF));
      for (int i = 0; i < 6; i++) pending_beats.push_back(mk_tick());
      wait_quiet();

      // Random part: the table is full now, so most behavior comes from
      // policy churn while the long last task keeps the run alive; the
      // lowered counts reach the all-done state.
      for (int p = 0; p < 28; p++) begin
         phase = idle_phase_type'(p % 4);
         csr_write(CSR_POLICY, CSR_DATA_W'($urandom_range(3)));
         csr_write(CSR_QUANTUM, (p % 7 == 0) ? CSR_DATA_W'(16'hFFFF)
                                             : CSR_DATA_W'($urandom_range(1, 6)));
         if (p % 9 == 8)
            csr_write(CSR_TASK_COUNT, CSR_DATA_W'($urandom_range(1, 4)));
         else if (p % 9 == 0)
            csr_write(CSR_TASK_COUNT, CSR_DATA_W'(16));
         nt = $urandom_range(38, 58);
         for (int i = 0; i < nt; i++)
            pending_beats.push_back(roll(85) ? mk_tick()
                                   : mk_load(TIME_W'($urandom), TIME_W'($urandom)));
         if (p == 5) begin
            // long receiver hold-off while the sender keeps offering ticks
            hold_req_cnt = hold_req_cnt + 1;
         end
         wait_quiet();
      end
      // sender pause until all results came back, then a last burst
      hold_send = 1'b1;
      pending_beats.push_back(mk_tick());
      while (sched_expect_q.size() != 0) @(posedge clock);
      hold_send = 1'b0;
      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d tick beats (%0d all-done) over four policies and idle mixes",
               ticks_checked, done_seen);
      if (errors == 0 && sched_expect_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
